FILE: design/bbcs_pkg.sv
// Shared types, codes and step decode functions for the battery blink code sequencer.
`timescale 1ns / 1ps

package bbcs_pkg;

   localparam int unsigned NUM_SRC   = 3;
   localparam int unsigned DUR_W     = 12;
   localparam int unsigned THR_W     = 7;
   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned IDX_W     = 4;
   localparam int unsigned SRC_W     = 2;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd100;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_LAYER = 2'd1;
   localparam logic [1:0] MODE_SHOW  = 2'd2;

   localparam logic [2:0] C_OFF     = 3'd0;
   localparam logic [2:0] C_BLUE    = 3'd1;
   localparam logic [2:0] C_GREEN   = 3'd2;
   localparam logic [2:0] C_RED     = 3'd4;
   localparam logic [2:0] C_MAGENTA = 3'd5;
   localparam logic [2:0] C_YELLOW  = 3'd6;
   localparam logic [2:0] C_WHITE   = 3'd7;

   localparam logic [2:0] D_MARK_ON  = 3'd0;
   localparam logic [2:0] D_MARK_OFF = 3'd1;
   localparam logic [2:0] D_LEVEL    = 3'd2;
   localparam logic [2:0] D_INV_ON   = 3'd3;
   localparam logic [2:0] D_INV_OFF  = 3'd4;
   localparam logic [2:0] D_GAP      = 3'd5;

   localparam logic [CSR_IDX_W-1:0] R_MARKER_ON  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] R_MARKER_OFF = 3'd1;
   localparam logic [CSR_IDX_W-1:0] R_LEVEL_ON   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] R_INVALID_ON = 3'd3;
   localparam logic [CSR_IDX_W-1:0] R_INVALID_OFF = 3'd4;
   localparam logic [CSR_IDX_W-1:0] R_SIDE_GAP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] R_LOW_MAX    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] R_MID_MAX    = 3'd7;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         layer_id;
      logic [LEVEL_W-1:0] left_pct;
      logic               left_ok;
      logic [LEVEL_W-1:0] right_pct;
      logic               right_ok;
      logic [LEVEL_W-1:0] pad_pct;
      logic               pad_ok;
   } req_type;

   typedef struct packed {
      logic red_on;
      logic green_on;
      logic blue_on;
      logic showing_battery;
   } rsp_type;

   typedef struct packed {
      logic [DUR_W-1:0] marker_on_ms;
      logic [DUR_W-1:0] marker_off_ms;
      logic [DUR_W-1:0] level_on_ms;
      logic [DUR_W-1:0] invalid_on_ms;
      logic [DUR_W-1:0] invalid_off_ms;
      logic [DUR_W-1:0] side_gap_ms;
      logic [THR_W-1:0] low_level_max;
      logic [THR_W-1:0] mid_level_max;
   } cfg_type;

   typedef struct packed {
      logic [2:0] colour;
      logic [2:0] dur;
      logic       last;
   } step_type;

   function automatic logic [2:0] layer_colour(input logic [7:0] layer);
      logic [2:0] c;
      unique case (layer)
         8'd0:    c = C_OFF;
         8'd1:    c = C_BLUE;
         8'd2:    c = C_GREEN;
         8'd3:    c = C_RED;
         8'd4:    c = C_MAGENTA;
         default: c = C_WHITE;
      endcase
      return c;
   endfunction

   function automatic logic reading_invalid(input logic [LEVEL_W-1:0] lvl, input logic ok);
      return !ok || (lvl > LEVEL_FULL);
   endfunction

   function automatic logic [2:0] level_colour(input logic [LEVEL_W-1:0] lvl,
                                               input logic [THR_W-1:0] lo,
                                               input logic [THR_W-1:0] mid);
      logic [2:0] c;
      if (lvl <= {1'b0, lo}) begin
         c = C_RED;
      end else if (lvl <= {1'b0, mid}) begin
         c = C_YELLOW;
      end else begin
         c = C_GREEN;
      end
      return c;
   endfunction

   // Step k of one source: optional gap, marker pairs, then the level part.
   function automatic step_type step_decode(input logic [SRC_W-1:0] src,
                                            input logic [IDX_W-1:0] idx,
                                            input logic             invalid,
                                            input logic [2:0]       lvl_col);
      step_type         s;
      logic [IDX_W-1:0] m;
      logic [IDX_W-1:0] marks;
      logic [IDX_W-1:0] j;
      logic [SRC_W-1:0] src_p1;
      src_p1 = src + 2'd1;
      m      = idx - {{(IDX_W-1){1'b0}}, (src != '0)};
      marks  = {1'b0, src_p1, 1'b0};
      j      = m - marks;
      s      = '0;
      if ((src != '0) && (idx == '0)) begin
         s.colour = C_OFF;
         s.dur    = D_GAP;
      end else if (m < marks) begin
         s.colour = m[0] ? C_OFF : C_WHITE;
         s.dur    = m[0] ? D_MARK_OFF : D_MARK_ON;
      end else if (invalid) begin
         s.colour = (j == 4'd1) ? C_OFF : C_MAGENTA;
         s.dur    = (j == 4'd1) ? D_INV_OFF : D_INV_ON;
         s.last   = (j == 4'd2);
      end else begin
         s.colour = lvl_col;
         s.dur    = D_LEVEL;
         s.last   = 1'b1;
      end
      return s;
   endfunction

   function automatic logic [DUR_W-1:0] dur_ticks(input cfg_type cfg, input logic [2:0] dur);
      logic [DUR_W-1:0] t;
      unique case (dur)
         D_MARK_ON:  t = cfg.marker_on_ms;
         D_MARK_OFF: t = cfg.marker_off_ms;
         D_LEVEL:    t = cfg.level_on_ms;
         D_INV_ON:   t = cfg.invalid_on_ms;
         D_INV_OFF:  t = cfg.invalid_off_ms;
         default:    t = cfg.side_gap_ms;
      endcase
      if (t == '0) begin
         t = {{(DUR_W-1){1'b0}}, 1'b1};
      end
      return t;
   endfunction

endpackage

FILE: design/battery_blink_code_sequencer.sv
// Top level of the battery blink code sequencer: handshakes, config registers, playback core.
`timescale 1ns / 1ps

// Takes one transaction per clock cycle while no pending result is held back; its result is
// offered in the cycle after acceptance and stays in the output register until taken. The
// LED drive and playback flag registers are the result register, so a new transaction
// enters in the same cycle that the pending result leaves. Config writes are always ready.

module battery_blink_code_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bbcs_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bbcs_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bbcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbcs_pkg::DUR_W-1:0]         csr_data
);

   bbcs_pkg::cfg_type cfg;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_fire;
   logic [2:0]        led_colour;
   logic              playing;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign rsp_data.red_on          = led_colour[2];
   assign rsp_data.green_on        = led_colour[1];
   assign rsp_data.blue_on         = led_colour[0];
   assign rsp_data.showing_battery = playing;

   // hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   bbcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bbcs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_fire),
      .req        (req_data),
      .cfg        (cfg),
      .led_colour (led_colour),
      .playing    (playing)
   );

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_show_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.mode == bbcs_pkg::MODE_SHOW) |=> rsp_data.showing_battery)
      else $error("show request did not start playback");

   a_layer_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.mode == bbcs_pkg::MODE_LAYER) && !rsp_data.showing_battery
      |=> {rsp_data.red_on, rsp_data.green_on, rsp_data.blue_on}
          == bbcs_pkg::layer_colour($past(req_data.layer_id)))
      else $error("layer colour not shown while idle");

   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.mode == bbcs_pkg::MODE_TICK) && !rsp_data.showing_battery
      |=> $stable(rsp_data))
      else $error("tick changed LED while idle");

endmodule

FILE: design/bbcs_csr.sv
// Configuration register file for the battery blink code sequencer.
`timescale 1ns / 1ps

module bbcs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bbcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbcs_pkg::DUR_W-1:0]         csr_data,
   output bbcs_pkg::cfg_type                  cfg
);

   bbcs_pkg::cfg_type cfg_ff;
   bbcs_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bbcs_pkg::R_MARKER_ON:   cfg_in.marker_on_ms   = csr_data;
            bbcs_pkg::R_MARKER_OFF:  cfg_in.marker_off_ms  = csr_data;
            bbcs_pkg::R_LEVEL_ON:    cfg_in.level_on_ms    = csr_data;
            bbcs_pkg::R_INVALID_ON:  cfg_in.invalid_on_ms  = csr_data;
            bbcs_pkg::R_INVALID_OFF: cfg_in.invalid_off_ms = csr_data;
            bbcs_pkg::R_SIDE_GAP:    cfg_in.side_gap_ms    = csr_data;
            bbcs_pkg::R_LOW_MAX:     cfg_in.low_level_max  = csr_data[bbcs_pkg::THR_W-1:0];
            default:                 cfg_in.mid_level_max  = csr_data[bbcs_pkg::THR_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.marker_on_ms   <= 12'd160;
         cfg_ff.marker_off_ms  <= 12'd140;
         cfg_ff.level_on_ms    <= 12'd1200;
         cfg_ff.invalid_on_ms  <= 12'd250;
         cfg_ff.invalid_off_ms <= 12'd150;
         cfg_ff.side_gap_ms    <= 12'd300;
         cfg_ff.low_level_max  <= 7'd15;
         cfg_ff.mid_level_max  <= 7'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/bbcs_core.sv
// Playback state and combinational next-state logic of the blink code sequencer.
`timescale 1ns / 1ps

module bbcs_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  bbcs_pkg::req_type req,
   input  bbcs_pkg::cfg_type cfg,
   output logic [2:0]        led_colour,
   output logic              playing
);

   logic [7:0]                       layer_ff, layer_in;
   logic [bbcs_pkg::LEVEL_W-1:0]     lvl_ff [bbcs_pkg::NUM_SRC];
   logic [bbcs_pkg::LEVEL_W-1:0]     lvl_in [bbcs_pkg::NUM_SRC];
   logic [bbcs_pkg::NUM_SRC-1:0]     ok_ff, ok_in;
   logic [bbcs_pkg::SRC_W-1:0]       src_ff, src_in;
   logic [bbcs_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [bbcs_pkg::DUR_W-1:0]       ticks_ff, ticks_in;
   logic                             playing_ff, playing_in;
   logic [2:0]                       led_ff, led_in;

   logic [bbcs_pkg::SRC_W-1:0]       sel_src;
   logic [bbcs_pkg::IDX_W-1:0]       sel_idx;
   logic [bbcs_pkg::LEVEL_W-1:0]     sel_lvl;
   logic                             sel_ok;
   logic                             do_advance;
   logic [bbcs_pkg::DUR_W-1:0]       ticks_dec;
   bbcs_pkg::step_type               step;

   assign led_colour = led_ff;
   assign playing    = playing_ff;
   assign ticks_dec  = ticks_ff - {{(bbcs_pkg::DUR_W-1){1'b0}}, (ticks_ff != '0)};

   always_comb begin
      if (req.mode == bbcs_pkg::MODE_SHOW) begin
         sel_src = '0;
         sel_idx = '0;
         sel_lvl = req.left_pct;
         sel_ok  = req.left_ok;
      end else begin
         sel_src = src_ff;
         sel_idx = idx_ff;
         case (src_ff)
            2'd0: begin
               sel_lvl = lvl_ff[0];
               sel_ok  = ok_ff[0];
            end
            2'd1: begin
               sel_lvl = lvl_ff[1];
               sel_ok  = ok_ff[1];
            end
            default: begin
               sel_lvl = lvl_ff[2];
               sel_ok  = ok_ff[2];
            end
         endcase
      end
      step = bbcs_pkg::step_decode(sel_src, sel_idx,
                                   bbcs_pkg::reading_invalid(sel_lvl, sel_ok),
                                   bbcs_pkg::level_colour(sel_lvl, cfg.low_level_max,
                                                          cfg.mid_level_max));
   end

   always_comb begin
      layer_in   = layer_ff;
      lvl_in     = lvl_ff;
      ok_in      = ok_ff;
      src_in     = src_ff;
      idx_in     = idx_ff;
      ticks_in   = ticks_ff;
      playing_in = playing_ff;
      led_in     = led_ff;
      do_advance = 1'b0;
      if (accept) begin
         case (req.mode)
            bbcs_pkg::MODE_TICK: begin
               if (playing_ff) begin
                  ticks_in   = ticks_dec;
                  do_advance = (ticks_dec == '0);
               end
            end
            bbcs_pkg::MODE_LAYER: begin
               layer_in = req.layer_id;
               if (!playing_ff) begin
                  led_in = bbcs_pkg::layer_colour(req.layer_id);
               end
            end
            bbcs_pkg::MODE_SHOW: begin
               lvl_in[0]  = req.left_pct;
               lvl_in[1]  = req.right_pct;
               lvl_in[2]  = req.pad_pct;
               ok_in      = {req.pad_ok, req.right_ok, req.left_ok};
               playing_in = 1'b1;
               do_advance = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (do_advance) begin
         if (sel_src == bbcs_pkg::SRC_W'(bbcs_pkg::NUM_SRC)) begin
            playing_in = 1'b0;
            led_in     = bbcs_pkg::layer_colour(layer_ff);
         end else begin
            led_in   = step.colour;
            ticks_in = bbcs_pkg::dur_ticks(cfg, step.dur);
            if (step.last) begin
               src_in = sel_src + 2'd1;
               idx_in = '0;
            end else begin
               src_in = sel_src;
               idx_in = sel_idx + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff   <= '0;
         lvl_ff     <= '{default: '0};
         ok_ff      <= '0;
         src_ff     <= '0;
         idx_ff     <= '0;
         ticks_ff   <= '0;
         playing_ff <= 1'b0;
         led_ff     <= bbcs_pkg::C_OFF;
      end else begin
         layer_ff   <= layer_in;
         lvl_ff     <= lvl_in;
         ok_ff      <= ok_in;
         src_ff     <= src_in;
         idx_ff     <= idx_in;
         ticks_ff   <= ticks_in;
         playing_ff <= playing_in;
         led_ff     <= led_in;
      end
   end

endmodule

FILE: tb/battery_blink_code_checker.sv
// Checker: predicts the LED result of every transaction of the blink code sequencer and compares.
`timescale 1ns / 1ps

module battery_blink_code_checker
   import bbcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]     csr_data,
   output int                   fail_count,
   output int                   waiting,
   output int                   checked,
   output int                   codes_done
);

   localparam int STEP_CAP     = 24;
   localparam int REPORT_LIMIT = 10;

   cfg_type            regs;
   logic [7:0]         layer_now;
   logic [LEVEL_W-1:0] level_seen [NUM_SRC];
   logic               ok_seen [NUM_SRC];
   int                 next_step;
   logic [DUR_W-1:0]   ticks_to_go;
   logic               code_active;
   logic [2:0]         led;

   logic [2:0]         code_colour [STEP_CAP];
   logic [2:0]         code_dur [STEP_CAP];
   int                 code_len;

   rsp_type            led_expected_q [$];
   int                 fails = 0;
   int                 seen = 0;
   int                 finished = 0;

   function automatic logic [2:0] layer_led(input logic [7:0] id);
      case (id)
         8'd0:    return C_OFF;
         8'd1:    return C_BLUE;
         8'd2:    return C_GREEN;
         8'd3:    return C_RED;
         8'd4:    return C_MAGENTA;
         default: return C_WHITE;
      endcase
   endfunction

   function automatic logic [DUR_W-1:0] step_ticks(input logic [2:0] dur);
      logic [DUR_W-1:0] t;
      case (dur)
         D_MARK_ON:  t = regs.marker_on_ms;
         D_MARK_OFF: t = regs.marker_off_ms;
         D_LEVEL:    t = regs.level_on_ms;
         D_INV_ON:   t = regs.invalid_on_ms;
         D_INV_OFF:  t = regs.invalid_off_ms;
         default:    t = regs.side_gap_ms;
      endcase
      return (t == '0) ? DUR_W'(1) : t;
   endfunction

   task automatic add_step(input logic [2:0] colour, input logic [2:0] dur);
      if (code_len < STEP_CAP) begin
         code_colour[code_len] = colour;
         code_dur[code_len]    = dur;
         code_len++;
      end
   endtask

   task automatic compose_code();
      logic [2:0] shade;
      code_len = 0;
      for (int src = 0; src < NUM_SRC; src++) begin
         if (src > 0) begin
            add_step(C_OFF, D_GAP);
         end
         for (int k = 0; k <= src; k++) begin
            add_step(C_WHITE, D_MARK_ON);
            add_step(C_OFF, D_MARK_OFF);
         end
         if (!ok_seen[src] || level_seen[src] > LEVEL_FULL) begin
            add_step(C_MAGENTA, D_INV_ON);
            add_step(C_OFF, D_INV_OFF);
            add_step(C_MAGENTA, D_INV_ON);
         end else begin
            if (level_seen[src] <= {1'b0, regs.low_level_max}) begin
               shade = C_RED;
            end else if (level_seen[src] <= {1'b0, regs.mid_level_max}) begin
               shade = C_YELLOW;
            end else begin
               shade = C_GREEN;
            end
            add_step(shade, D_LEVEL);
         end
      end
   endtask

   task automatic start_next_step();
      compose_code();
      if (next_step >= code_len) begin
         code_active = 1'b0;
         led         = layer_led(layer_now);
         finished++;
      end else begin
         led         = code_colour[next_step];
         ticks_to_go = step_ticks(code_dur[next_step]);
         next_step++;
      end
   endtask

   task automatic apply_item(input req_type r);
      case (r.mode)
         MODE_TICK: begin
            if (code_active) begin
               if (ticks_to_go != '0) begin
                  ticks_to_go = ticks_to_go - DUR_W'(1);
               end
               if (ticks_to_go == '0) begin
                  start_next_step();
               end
            end
         end
         MODE_LAYER: begin
            layer_now = r.layer_id;
            if (!code_active) begin
               led = layer_led(layer_now);
            end
         end
         MODE_SHOW: begin
            level_seen[0] = r.left_pct;
            ok_seen[0]    = r.left_ok;
            level_seen[1] = r.right_pct;
            ok_seen[1]    = r.right_ok;
            level_seen[2] = r.pad_pct;
            ok_seen[2]    = r.pad_ok;
            code_active   = 1'b1;
            next_step     = 0;
            start_next_step();
         end
         default: ;
      endcase
      led_expected_q.push_back('{red_on: led[2], green_on: led[1], blue_on: led[0],
                                 showing_battery: code_active});
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      seen++;
      if (led_expected_q.size() == 0) begin
         fails++;
         if (fails <= REPORT_LIMIT) begin
            $display("Unexpected result %0d: r%b g%b b%b show%b with no transaction pending",
                     seen, got.red_on, got.green_on, got.blue_on, got.showing_battery);
         end
      end else begin
         want = led_expected_q.pop_front();
         if (got.red_on !== want.red_on || got.green_on !== want.green_on ||
             got.blue_on !== want.blue_on || got.showing_battery !== want.showing_battery) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
               $display("Mismatch on result %0d: expected r%b g%b b%b show%b,",
                        seen, want.red_on, want.green_on, want.blue_on, want.showing_battery,
                        " got r%b g%b b%b show%b",
                        got.red_on, got.green_on, got.blue_on, got.showing_battery);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs = '{marker_on_ms: 12'd160, marker_off_ms: 12'd140, level_on_ms: 12'd1200,
                  invalid_on_ms: 12'd250, invalid_off_ms: 12'd150, side_gap_ms: 12'd300,
                  low_level_max: 7'd15, mid_level_max: 7'd50};
         layer_now   = '0;
         next_step   = 0;
         ticks_to_go = '0;
         code_active = 1'b0;
         led         = C_OFF;
         for (int s = 0; s < NUM_SRC; s++) begin
            level_seen[s] = '0;
            ok_seen[s]    = 1'b0;
         end
         led_expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            compare_result(rsp_data);
         end
         if (req_valid && req_ready) begin
            apply_item(req_data);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               R_MARKER_ON:   regs.marker_on_ms   = csr_data;
               R_MARKER_OFF:  regs.marker_off_ms  = csr_data;
               R_LEVEL_ON:    regs.level_on_ms    = csr_data;
               R_INVALID_ON:  regs.invalid_on_ms  = csr_data;
               R_INVALID_OFF: regs.invalid_off_ms = csr_data;
               R_SIDE_GAP:    regs.side_gap_ms    = csr_data;
               R_LOW_MAX:     regs.low_level_max  = csr_data[THR_W-1:0];
               default:       regs.mid_level_max  = csr_data[THR_W-1:0];
            endcase
         end
      end
      fail_count <= fails;
      waiting    <= led_expected_q.size();
      checked    <= seen;
      codes_done <= finished;
   end

endmodule

FILE: tb/battery_blink_code_sequencer_tb.sv
// Testbench top: drives requests, register writes and result back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module battery_blink_code_sequencer_tb;
   import bbcs_pkg::*;

   localparam logic [1:0] MODE_IDLE = 2'd3;
   localparam int PHASE_ITEMS = 240;
   localparam int SLOW_ITEMS  = 80;
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 3000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DUR_W-1:0]     csr_data;

   int      fail_count;
   int      waiting;
   int      checked;
   int      codes_done;
   int      holds_asked = 0;
   int      idle_cycles = 0;
   int      calm_items = 0;
   int      sent_tick = 0;
   int      sent_layer = 0;
   int      sent_show = 0;
   int      sent_idle = 0;
   int      settings_used = 1;
   cfg_type setting;

   battery_blink_code_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   battery_blink_code_checker led_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .waiting    (waiting),
      .checked    (checked),
      .codes_done (codes_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stalls, calm stretches and the requested long hold-offs
   initial begin
      int stall;
      int calm;
      int holds_done;
      stall      = 0;
      calm       = 0;
      holds_done = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_asked != holds_done) begin
            holds_done++;
            stall = LONG_HOLD;
         end else if (stall == 0 && calm == 0) begin
            case ($urandom_range(0, 9))
               0:       calm = $urandom_range(20, 200);
               1, 2:    stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                          : $urandom_range(8, 40);
               default: ;
            endcase
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (calm > 0) begin
               calm--;
            end
         end
      end
   end

   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return {1'b0, setting.low_level_max};
         2:       return {1'b0, setting.low_level_max} + 8'd1;
         3:       return {1'b0, setting.mid_level_max};
         4:       return {1'b0, setting.mid_level_max} + 8'd1;
         5:       return LEVEL_FULL;
         6:       return LEVEL_FULL + 8'd1;
         7:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_type make_item(input logic [1:0] mode);
      req_type r;
      r.mode      = mode;
      r.layer_id  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      r.left_pct  = pick_level();
      r.left_ok   = ($urandom_range(0, 4) != 0);
      r.right_pct = pick_level();
      r.right_ok  = ($urandom_range(0, 4) != 0);
      r.pad_pct   = pick_level();
      r.pad_ok    = ($urandom_range(0, 4) != 0);
      return r;
   endfunction

   function automatic req_type compose_req(input logic [1:0] mode, input logic [7:0] layer,
                                           input logic [7:0] left, input logic left_ok,
                                           input logic [7:0] right, input logic right_ok,
                                           input logic [7:0] pad, input logic pad_ok);
      return '{mode: mode, layer_id: layer, left_pct: left, left_ok: left_ok,
               right_pct: right, right_ok: right_ok, pad_pct: pad, pad_ok: pad_ok};
   endfunction

   function automatic logic [1:0] random_mode();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll == 0) begin
         return MODE_SHOW;
      end else if (roll <= 8) begin
         return MODE_LAYER;
      end else if (roll <= 12) begin
         return MODE_IDLE;
      end
      return MODE_TICK;
   endfunction

   function automatic cfg_type random_setting(input int longest);
      cfg_type c;
      c.marker_on_ms   = DUR_W'($urandom_range(0, longest));
      c.marker_off_ms  = DUR_W'($urandom_range(0, longest));
      c.level_on_ms    = DUR_W'($urandom_range(0, longest));
      c.invalid_on_ms  = DUR_W'($urandom_range(0, longest));
      c.invalid_off_ms = DUR_W'($urandom_range(0, longest));
      c.side_gap_ms    = DUR_W'($urandom_range(0, longest));
      c.low_level_max  = THR_W'($urandom_range(0, 100));
      c.mid_level_max  = THR_W'($urandom_range(0, 100));
      return c;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = 0;
      if (calm_items > 0) begin
         calm_items--;
      end else begin
         case ($urandom_range(0, 19))
            0:                   calm_items = $urandom_range(20, 120);
            1, 2:                gap = $urandom_range(10, 40);
            3, 4, 5, 6, 7, 8, 9: gap = $urandom_range(1, 3);
            default:             ;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      case (item.mode)
         MODE_TICK:  sent_tick++;
         MODE_LAYER: sent_layer++;
         MODE_SHOW:  sent_show++;
         default:    sent_idle++;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs(input cfg_type c);
      setting = c;
      write_reg(R_MARKER_ON, c.marker_on_ms);
      write_reg(R_MARKER_OFF, c.marker_off_ms);
      write_reg(R_LEVEL_ON, c.level_on_ms);
      write_reg(R_INVALID_ON, c.invalid_on_ms);
      write_reg(R_INVALID_OFF, c.invalid_off_ms);
      write_reg(R_SIDE_GAP, c.side_gap_ms);
      write_reg(R_LOW_MAX, DUR_W'(c.low_level_max));
      write_reg(R_MID_MAX, DUR_W'(c.mid_level_max));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // battery requests, each followed by a random run of mostly ticks with noise mixed in
   task automatic play_phase(input int count, input bit squeeze);
      int budget;
      int run;
      int longest;
      bit held;
      longest = 1;
      held    = 1'b0;
      if (setting.marker_on_ms > longest)   longest = setting.marker_on_ms;
      if (setting.marker_off_ms > longest)  longest = setting.marker_off_ms;
      if (setting.level_on_ms > longest)    longest = setting.level_on_ms;
      if (setting.invalid_on_ms > longest)  longest = setting.invalid_on_ms;
      if (setting.invalid_off_ms > longest) longest = setting.invalid_off_ms;
      if (setting.side_gap_ms > longest)    longest = setting.side_gap_ms;
      budget = count;
      while (budget > 0) begin
         send_item(make_item(MODE_SHOW));
         budget--;
         run = $urandom_range(4, (longest > 5) ? 120 : 23 * longest + 10);
         while (run > 0 && budget > 0) begin
            if (squeeze && !held && budget <= count / 2) begin
               holds_asked <= holds_asked + 1;
               held = 1'b1;
            end
            send_item(make_item(random_mode()));
            run--;
            budget--;
         end
      end
      wait_drained();
   endtask

   initial begin
      cfg_type c;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      setting   = '{marker_on_ms: 12'd160, marker_off_ms: 12'd140, level_on_ms: 12'd1200,
                    invalid_on_ms: 12'd250, invalid_off_ms: 12'd150, side_gap_ms: 12'd300,
                    low_level_max: 7'd15, mid_level_max: 7'd50};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_item(compose_req(MODE_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_LAYER, 8'd1, 8'hFF, 1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1));
      send_item(compose_req(MODE_LAYER, 8'd2, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_LAYER, 8'd3, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_LAYER, 8'd4, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_LAYER, 8'd5, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_LAYER, 8'd255, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_LAYER, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_IDLE, 8'd2, 8'hAA, 1'b1, 8'h55, 1'b0, 8'hFF, 1'b1));
      send_item(compose_req(MODE_LAYER, 8'd3, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_SHOW, 8'd0, 8'd0, 1'b1, 8'd100, 1'b1, 8'd255, 1'b1));
      send_item(compose_req(MODE_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_LAYER, 8'd4, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_IDLE, 8'd1, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_SHOW, 8'd0, 8'd101, 1'b1, 8'd15, 1'b0, 8'd16, 1'b1));
      send_item(compose_req(MODE_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      send_item(compose_req(MODE_SHOW, 8'd0, 8'd50, 1'b1, 8'd51, 1'b1, 8'd15, 1'b1));
      send_item(compose_req(MODE_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
      wait_drained();

      c = '{default: '0};
      program_regs(c);
      play_phase(PHASE_ITEMS, 1'b0);

      c = random_setting(3);
      c.low_level_max = 7'd100;
      c.mid_level_max = 7'd100;
      program_regs(c);
      play_phase(PHASE_ITEMS, 1'b1);

      c = random_setting(4);
      c.low_level_max = 7'd80;
      c.mid_level_max = 7'd20;
      program_regs(c);
      play_phase(PHASE_ITEMS, 1'b0);

      c = '{marker_on_ms: 12'hFFF, marker_off_ms: 12'hFFF, level_on_ms: 12'hFFF,
            invalid_on_ms: 12'hFFF, invalid_off_ms: 12'hFFF, side_gap_ms: 12'hFFF,
            low_level_max: 7'd100, mid_level_max: 7'd0};
      program_regs(c);
      play_phase(SLOW_ITEMS, 1'b1);

      program_regs(random_setting(5));
      play_phase(PHASE_ITEMS, 1'b0);

      program_regs(random_setting(2));
      play_phase(PHASE_ITEMS, 1'b0);

      repeat (4) @(posedge clock);
      $display("Sent %0d transactions (%0d ticks, %0d layer changes, %0d battery requests,",
               sent_tick + sent_layer + sent_show + sent_idle, sent_tick, sent_layer,
               sent_show, " %0d ignored) under %0d register settings", sent_idle,
               settings_used);
      $display("Checked %0d LED results, %0d blink codes played to the end,",
               checked, codes_done, " %0d long receiver hold-offs", holds_asked);
      if (fail_count == 0 && waiting == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: files.f
design/bbcs_pkg.sv
design/bbcs_csr.sv
design/bbcs_core.sv
design/battery_blink_code_sequencer.sv
tb/battery_blink_code_checker.sv
tb/battery_blink_code_sequencer_tb.sv
